// ----- sv/sdps_pkg.sv -----
// Shared types, widths and constants for the straight-drive profile step.
package sdps_pkg;

   // Field widths
   localparam int CRUISE_W  = 11;
   localparam int HEADING_W = 16;
   localparam int TICKS_W   = 20;
   localparam int GAIN_W    = 16;
   localparam int RATE_W    = 16;
   localparam int MINSPD_W  = 10;
   localparam int POS_W     = 21;
   localparam int ELAPSED_W = 24;
   localparam int VEL_W     = 12;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 20;

   // Internal widths
   localparam int SUM_W    = POS_W + 1;           // left + right
   localparam int REMAIN_W = TICKS_W + 1;         // half ticks left to go
   localparam int ERR_W    = HEADING_W + 2;       // heading difference, signed
   localparam int AERR_W   = 16;                  // folded |error| stays under 2^15
   localparam int MAG_W    = CRUISE_W;            // |cruise| up to 1024
   localparam int STEER_W  = 17;                  // |steer| stays under 2^17
   localparam int MIX_W    = 19;

   // Heading fold, hundredths of a degree (180 and 360 degrees)
   localparam logic signed [ERR_W-1:0] HALF_TURN = 18'sd18000;
   localparam logic signed [ERR_W-1:0] FULL_TURN = 18'sd36000;

   // Steer divide by 25600 = (x >> 10) / 25; the /25 is a reciprocal multiply,
   // exact for 22-bit dividends: ceil(2^28 / 25).
   localparam int             STEER_PRE_SHIFT = 10;
   localparam int             QUOT_IN_W       = 2 * GAIN_W - STEER_PRE_SHIFT;
   localparam int             RECIP_W         = 24;
   localparam int             RECIP_SHIFT     = 28;
   localparam logic [RECIP_W-1:0] RECIP_25    = 24'd10737419;

   localparam int ACC_SHIFT = 10;
   localparam int DEC_SHIFT = 11;

   localparam logic signed [VEL_W-1:0] VEL_MAX = 12'sd2047;
   localparam logic signed [VEL_W-1:0] VEL_MIN = -12'sd2048;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CRUISE_SPEED   = 3'd0,
      CSR_TARGET_HEADING = 3'd1,
      CSR_TARGET_TICKS   = 3'd2,
      CSR_STEER_GAIN     = 3'd3,
      CSR_ACCEL_RATE     = 3'd4,
      CSR_DECEL_RATE     = 3'd5,
      CSR_MIN_SPEED      = 3'd6
   } csr_index_type;

   // Per-word control flags carried down the pipe
   typedef struct packed {
      logic done;
      logic cruise_neg;
      logic err_neg;
   } mix_ctl_type;

   function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [MIX_W-1:0] v);
      logic signed [VEL_W-1:0] r;
      if (v > MIX_W'(VEL_MAX)) begin
         r = VEL_MAX;
      end else if (v < MIX_W'(VEL_MIN)) begin
         r = VEL_MIN;
      end else begin
         r = v[VEL_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- sv/sdps_mix.sv -----
// Final velocity mix: signed speed plus and minus steer, saturated, zero when done.
module sdps_mix (
   input  sdps_pkg::mix_ctl_type                 ctl,
   input  logic [sdps_pkg::MAG_W-1:0]            mag,
   input  logic [sdps_pkg::STEER_W-1:0]          steer,
   output logic signed [sdps_pkg::VEL_W-1:0]     left_velocity,
   output logic signed [sdps_pkg::VEL_W-1:0]     right_velocity,
   output logic                                  done_res
);
   import sdps_pkg::*;

   logic signed [MIX_W-1:0] mag_s;
   logic signed [MIX_W-1:0] steer_u;
   logic signed [MIX_W-1:0] speed;
   logic signed [MIX_W-1:0] steer_s;
   logic signed [MIX_W-1:0] left_sum;
   logic signed [MIX_W-1:0] right_sum;

   always_comb begin
      mag_s     = signed'({{(MIX_W-MAG_W){1'b0}}, mag});
      steer_u   = signed'({{(MIX_W-STEER_W){1'b0}}, steer});
      speed     = ctl.cruise_neg ? -mag_s : mag_s;
      steer_s   = ctl.err_neg ? -steer_u : steer_u;
      left_sum  = speed + steer_s;
      right_sum = speed - steer_s;
      if (ctl.done) begin
         left_velocity  = '0;
         right_velocity = '0;
      end else begin
         left_velocity  = sat_vel(left_sum);
         right_velocity = sat_vel(right_sum);
      end
      done_res = ctl.done;
   end

endmodule

// ----- sv/straight_drive_profile_step.sv -----
// An accepted req word reaches rsp_valid through all register stages, later if rsp stalls.
// Throughput: one word per cycle while rsp is not stalled; five register stages, each with its own valid bit.
// Stalls back up stage by stage, so bubbles close up and req stalls only when all are full.
// The longest stage is the 16x24 ramp multiply or the 22x24 reciprocal multiply.
// Reset (synchronous, active high) empties the pipe and clears all config registers to 0.
// Config writes land in a register and must be made while the pipe is empty.
module straight_drive_profile_step (
   input  logic                                  clock,
   input  logic                                  reset,
   // config write port
   input  logic                                  csr_we,
   input  logic [sdps_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sdps_pkg::CSR_DATA_W-1:0]       csr_wdata,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [sdps_pkg::POS_W-1:0]     req_left_position,
   input  logic signed [sdps_pkg::POS_W-1:0]     req_right_position,
   input  logic [sdps_pkg::HEADING_W-1:0]        req_heading_now,
   input  logic [sdps_pkg::ELAPSED_W-1:0]        req_elapsed_ms,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [sdps_pkg::VEL_W-1:0]     rsp_left_velocity,
   output logic signed [sdps_pkg::VEL_W-1:0]     rsp_right_velocity,
   output logic                                  rsp_done_res
);
   import sdps_pkg::*;

   // ------------------------------------------------------------------
   // Config registers
   // ------------------------------------------------------------------
   logic signed [CRUISE_W-1:0]  cruise_speed_ff;
   logic [HEADING_W-1:0]        target_heading_ff;
   logic [TICKS_W-1:0]          target_ticks_ff;
   logic [GAIN_W-1:0]           steer_gain_ff;
   logic [RATE_W-1:0]           accel_rate_ff;
   logic [RATE_W-1:0]           decel_rate_ff;
   logic [MINSPD_W-1:0]         min_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cruise_speed_ff   <= '0;
         target_heading_ff <= '0;
         target_ticks_ff   <= '0;
         steer_gain_ff     <= '0;
         accel_rate_ff     <= '0;
         decel_rate_ff     <= '0;
         min_speed_ff      <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CRUISE_SPEED:   cruise_speed_ff   <= signed'(csr_wdata[CRUISE_W-1:0]);
            CSR_TARGET_HEADING: target_heading_ff <= csr_wdata[HEADING_W-1:0];
            CSR_TARGET_TICKS:   target_ticks_ff   <= csr_wdata[TICKS_W-1:0];
            CSR_STEER_GAIN:     steer_gain_ff     <= csr_wdata[GAIN_W-1:0];
            CSR_ACCEL_RATE:     accel_rate_ff     <= csr_wdata[RATE_W-1:0];
            CSR_DECEL_RATE:     decel_rate_ff     <= csr_wdata[RATE_W-1:0];
            CSR_MIN_SPEED:      min_speed_ff      <= csr_wdata[MINSPD_W-1:0];
            default: ;  // unused index, write dropped
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline flow control: a stage loads when it is empty or the
   // stage below it moves on.
   // ------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   assign rdy5 = !v5_ff || !rsp_stall;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_stall = !rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: wheel sum and raw heading error
   // ------------------------------------------------------------------
   logic signed [SUM_W-1:0]     s1_sum_ff, s1_sum_in;
   logic signed [ERR_W-1:0]     s1_err_ff, s1_err_in;
   logic [ELAPSED_W-1:0]        s1_elapsed_ff;

   always_comb begin
      s1_sum_in = {req_left_position[POS_W-1], req_left_position}
                + {req_right_position[POS_W-1], req_right_position};
      s1_err_in = signed'({2'b00, target_heading_ff}) - signed'({2'b00, req_heading_now});
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_sum_ff     <= s1_sum_in;
         s1_err_ff     <= s1_err_in;
         s1_elapsed_ff <= req_elapsed_ms;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: done test, remaining distance, heading fold and magnitude
   // ------------------------------------------------------------------
   logic [SUM_W-1:0]            s2_asum;
   logic [SUM_W-1:0]            s2_goal;
   logic [SUM_W-1:0]            s2_left;
   logic signed [ERR_W-1:0]     s2_fold;
   logic [ERR_W-1:0]            s2_aerr_w;
   mix_ctl_type                 s2_ctl_ff, s2_ctl_in;
   logic [REMAIN_W-1:0]         s2_remain_ff;
   logic [AERR_W-1:0]           s2_aerr_ff;
   logic [ELAPSED_W-1:0]        s2_elapsed_ff;

   always_comb begin
      // mean position in half ticks; done once it reaches twice the target
      s2_asum = s1_sum_ff[SUM_W-1] ? unsigned'(-s1_sum_ff) : unsigned'(s1_sum_ff);
      s2_goal = {1'b0, target_ticks_ff, 1'b0};
      s2_left = s2_goal - s2_asum;
      // fold once into +/-180 degrees
      priority if (s1_err_ff > HALF_TURN) begin
         s2_fold = s1_err_ff - FULL_TURN;
      end else if (s1_err_ff < -HALF_TURN) begin
         s2_fold = s1_err_ff + FULL_TURN;
      end else begin
         s2_fold = s1_err_ff;
      end
      s2_aerr_w = s2_fold[ERR_W-1] ? unsigned'(-s2_fold) : unsigned'(s2_fold);
      s2_ctl_in.done       = (s2_asum >= s2_goal);
      s2_ctl_in.cruise_neg = 1'b0;  // filled in at stage 4
      s2_ctl_in.err_neg    = s2_fold[ERR_W-1];
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_ctl_ff     <= s2_ctl_in;
         s2_remain_ff  <= s2_left[REMAIN_W-1:0];
         s2_aerr_ff    <= s2_aerr_w[AERR_W-1:0];
         s2_elapsed_ff <= s1_elapsed_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: the three products
   // ------------------------------------------------------------------
   localparam int ACC_P_W = RATE_W + ELAPSED_W;
   localparam int DEC_P_W = RATE_W + REMAIN_W;
   localparam int STR_P_W = GAIN_W + AERR_W;

   mix_ctl_type                 s3_ctl_ff;
   logic [ACC_P_W-1:0]          s3_acc_p_ff;
   logic [DEC_P_W-1:0]          s3_dec_p_ff;
   logic [STR_P_W-1:0]          s3_str_p_ff;

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_ctl_ff   <= s2_ctl_ff;
         s3_acc_p_ff <= ACC_P_W'(accel_rate_ff) * ACC_P_W'(s2_elapsed_ff);
         s3_dec_p_ff <= DEC_P_W'(decel_rate_ff) * DEC_P_W'(s2_remain_ff);
         s3_str_p_ff <= STR_P_W'(steer_gain_ff) * STR_P_W'(s2_aerr_ff);
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: ramps, trapezoid minimum, reciprocal multiply for /25
   // ------------------------------------------------------------------
   localparam int ACC_W  = ACC_P_W - ACC_SHIFT + 1;
   localparam int DEC_W  = DEC_P_W - DEC_SHIFT + 1;
   localparam int QUOT_P_W = QUOT_IN_W + RECIP_W;

   logic [ACC_W-1:0]            s4_acc;
   logic [DEC_W-1:0]            s4_dec;
   logic [MAG_W-1:0]            s4_cruise_abs;
   logic [MAG_W-1:0]            s4_mag_in;
   mix_ctl_type                 s4_ctl_in;
   mix_ctl_type                 s4_ctl_ff;
   logic [MAG_W-1:0]            s4_mag_ff;
   logic [QUOT_P_W-1:0]         s4_quot_p_ff;

   always_comb begin
      s4_acc = {1'b0, s3_acc_p_ff[ACC_P_W-1:ACC_SHIFT]} + ACC_W'(min_speed_ff);
      s4_dec = {1'b0, s3_dec_p_ff[DEC_P_W-1:DEC_SHIFT]} + DEC_W'(min_speed_ff);
      s4_cruise_abs = cruise_speed_ff[CRUISE_W-1] ? unsigned'(-cruise_speed_ff)
                                                  : unsigned'(cruise_speed_ff);
      s4_mag_in = s4_cruise_abs;
      if (s4_acc < ACC_W'(s4_mag_in)) begin
         s4_mag_in = s4_acc[MAG_W-1:0];
      end
      if (s4_dec < DEC_W'(s4_mag_in)) begin
         s4_mag_in = s4_dec[MAG_W-1:0];
      end
      s4_ctl_in            = s3_ctl_ff;
      s4_ctl_in.cruise_neg = cruise_speed_ff[CRUISE_W-1];
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         s4_ctl_ff    <= s4_ctl_in;
         s4_mag_ff    <= s4_mag_in;
         s4_quot_p_ff <= QUOT_P_W'(s3_str_p_ff[STR_P_W-1:STEER_PRE_SHIFT])
                       * QUOT_P_W'(RECIP_25);
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: mix, saturate, output register
   // ------------------------------------------------------------------
   logic [STEER_W-1:0]          s5_steer;
   logic signed [VEL_W-1:0]     s5_left;
   logic signed [VEL_W-1:0]     s5_right;
   logic                        s5_done;
   logic signed [VEL_W-1:0]     rsp_left_ff;
   logic signed [VEL_W-1:0]     rsp_right_ff;
   logic                        rsp_done_ff;

   assign s5_steer = s4_quot_p_ff[RECIP_SHIFT+STEER_W-1:RECIP_SHIFT];

   sdps_mix u_mix (
      .ctl            (s4_ctl_ff),
      .mag            (s4_mag_ff),
      .steer          (s5_steer),
      .left_velocity  (s5_left),
      .right_velocity (s5_right),
      .done_res       (s5_done)
   );

   always_ff @(posedge clock) begin
      if (rdy5) begin
         rsp_left_ff  <= s5_left;
         rsp_right_ff <= s5_right;
         rsp_done_ff  <= s5_done;
      end
   end

   assign rsp_valid          = v5_ff;
   assign rsp_left_velocity  = rsp_left_ff;
   assign rsp_right_velocity = rsp_right_ff;
   assign rsp_done_res       = rsp_done_ff;

endmodule

// ----- sv/sdps_checker.sv -----
// Port-level checks for the straight-drive profile step, bound to the top level.
module sdps_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [sdps_pkg::VEL_W-1:0]     rsp_left_velocity,
   input logic signed [sdps_pkg::VEL_W-1:0]     rsp_right_velocity,
   input logic                                  rsp_done_res
);
   import sdps_pkg::*;

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // input only backs up when the output is full and stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req stalled with output free");

   // done word carries zero velocities
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> (rsp_left_velocity == '0 && rsp_right_velocity == '0))
      else $error("done word with nonzero velocity");

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_left_velocity)
                                    && $stable(rsp_right_velocity) && $stable(rsp_done_res)))
      else $error("stalled rsp word changed");

endmodule

bind straight_drive_profile_step sdps_checker u_sdps_checker (.*);
